// File: rtl/rsi_pkg.sv
// Shared widths, payload types and the saturation helper for the ray-sphere tester.
// No dependencies; every other file in rtl/ imports this package.
package rsi_pkg;

  localparam int CW     = 32;            // coordinate width
  localparam int FB     = 16;            // fraction bits
  localparam int RW     = CW - 1;        // radius register width
  localparam int MW     = 8;             // material id width
  localparam int CFG_IW = 3;             // register index width
  localparam int VW     = CW + 1;        // origin minus center
  localparam int AW     = 2 * CW;        // a = D.D, unsigned
  localparam int HW     = 2 * CW + 2;    // h = D.V, signed
  localparam int CCW    = 2 * CW + 4;    // c = V.V - R*R, signed
  localparam int QW     = 4 * CW + 4;    // discriminant, signed
  localparam int SW     = QW / 2;        // square root width
  localparam int NUMW   = SW + 2;        // -h +/- s, signed
  localparam int QB     = 32;            // quotient bits, one per divider stage
  localparam int DNW    = AW;            // divisor width
  localparam int NW     = DNW + QB;      // dividend width
  localparam int TW     = QB + 2;        // signed floor quotient
  localparam int SATW   = 2 * CW;        // input width of the saturation helper

  typedef enum logic [CFG_IW-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_RADIUS,
    REG_MATERIAL
  } cfg_reg_t;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    coord_t [2:0] org;
    coord_t [2:0] dir;
    coord_t       t_min;
    coord_t       t_max;
  } ray_t;

  typedef struct packed {
    ray_t                   ray;
    logic signed [HW-1:0]   h;
    logic [AW-1:0]          a;
    logic                   miss;
  } sq_side_t;

  typedef struct packed {
    logic                 vld;
    logic signed [QW-1:0] disc;
    sq_side_t             side;
  } sq_in_t;

  typedef struct packed {
    logic          vld;
    logic [SW-1:0] root;
    sq_side_t      side;
  } sq_out_t;

  // Sideband carried beside the near root division.
  typedef struct packed {
    logic miss;
    ray_t ray;
  } tside_t;

  // Sideband carried beside the x normal division.
  typedef struct packed {
    logic         hit;
    coord_t       t;
    coord_t [2:0] pnt;
  } nside_t;

  localparam int SIDE_W = $bits(tside_t);

  typedef struct packed {
    logic              vld;
    logic [NW-1:0]     num;
    logic [DNW-1:0]    den;
    logic              neg;
    logic              ovf;
    logic [SIDE_W-1:0] side;
  } div_in_t;

  typedef struct packed {
    logic              vld;
    logic [QB-1:0]     quo;
    logic              rnz;
    logic              neg;
    logic              ovf;
    logic [SIDE_W-1:0] side;
  } div_out_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic coord_t sat_coord(input logic signed [SATW-1:0] v);
    logic top_ones;
    logic top_zeros;
    top_ones  = &v[SATW-1:CW-1];
    top_zeros = ~|v[SATW-1:CW-1];
    if (top_ones || top_zeros) begin
      sat_coord = v[CW-1:0];
    end else if (v[SATW-1]) begin
      sat_coord = COORD_MIN;
    end else begin
      sat_coord = COORD_MAX;
    end
  endfunction

endpackage

// File: rtl/rsi_if.sv
// Handshake interfaces of the ray-sphere tester: ray input, result output, register writes.
// Depends on rsi_pkg for the coordinate type and index width.
interface rsi_ray_if import rsi_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  coord_t dir_x;
  coord_t dir_y;
  coord_t dir_z;
  coord_t t_min;
  coord_t t_max;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_min, t_max, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                t_min, t_max, output ready);
endinterface

interface rsi_hit_if import rsi_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          hit;
  coord_t        hit_t;
  coord_t        point_x;
  coord_t        point_y;
  coord_t        point_z;
  coord_t        normal_x;
  coord_t        normal_y;
  coord_t        normal_z;
  logic [MW-1:0] hit_material;

  modport source (output valid, hit, hit_t, point_x, point_y, point_z, normal_x, normal_y,
                  normal_z, hit_material, input ready);
  modport sink (input valid, hit, hit_t, point_x, point_y, point_z, normal_x, normal_y,
                normal_z, hit_material, output ready);
endinterface

interface rsi_cfg_if import rsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/rsi_quad.sv
// Quadratic setup: V = O - C, the dot products a, h, c and the discriminant h*h - a*c.
// Seven register stages; wide products are split into partial products. Uses rsi_pkg.
module rsi_quad import rsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  ray_t              in_ray,
  input  coord_t [2:0]      center,
  input  logic [RW-1:0]     radius,
  output sq_in_t            out
);

  logic                   s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld;
  ray_t                   s1_ray, s2_ray, s3_ray, s4_ray, s5_ray, s6_ray, s7_ray;
  logic signed [VW-1:0]   s1_v [3];
  logic [AW-1:0]          s2_dd [3];
  logic signed [VW+CW-1:0] s2_dv [3];
  logic [2*VW-1:0]        s2_vv [3];
  logic [2*RW-1:0]        s2_rr;
  logic [AW-1:0]          s3_a, s4_a, s5_a, s6_a, s7_a;
  logic signed [HW-1:0]   s3_h, s4_h, s5_h, s6_h, s7_h;
  logic signed [CCW-1:0]  s3_c;
  logic [HW-2:0]          s4_hm;
  logic [CCW-2:0]         s4_cm;
  logic                   s4_cneg, s5_cneg, s6_cneg;
  logic [63:0]            s5_phh;
  logic [64:0]            s5_phx;
  logic [65:0]            s5_pll;
  logic [65:0]            s5_pa0, s5_pa2;
  logic [64:0]            s5_pa1, s5_pa3;
  logic [QW-1:0]          s6_h2, s6_ac;
  logic signed [QW-1:0]   s7_disc;
  logic signed [HW-1:0]   h_abs;
  logic signed [CCW-1:0]  c_abs;

  always_comb begin
    h_abs = s3_h[HW-1] ? -s3_h : s3_h;
    c_abs = s3_c[CCW-1] ? -s3_c : s3_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: offset of the origin from the center.
      s1_ray <= in_ray;
      for (int i = 0; i < 3; i++) begin
        s1_v[i] <= $signed({in_ray.org[i][CW-1], in_ray.org[i]})
                 - $signed({center[i][CW-1], center[i]});
      end
      // Stage 2: the nine products and R*R.
      s2_ray <= s1_ray;
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= $signed(s1_ray.dir[i]) * $signed(s1_ray.dir[i]);
        s2_dv[i] <= $signed(s1_ray.dir[i]) * s1_v[i];
        s2_vv[i] <= s1_v[i] * s1_v[i];
      end
      s2_rr <= radius * radius;
      // Stage 3: dot products.
      s3_ray <= s2_ray;
      s3_a   <= s2_dd[0] + s2_dd[1] + s2_dd[2];
      s3_h   <= s2_dv[0] + s2_dv[1] + s2_dv[2];
      s3_c   <= s2_vv[0] + s2_vv[1] + s2_vv[2] - s2_rr;
      // Stage 4: magnitudes for the split products.
      s4_ray  <= s3_ray;
      s4_a    <= s3_a;
      s4_h    <= s3_h;
      s4_hm   <= h_abs[HW-2:0];
      s4_cm   <= c_abs[CCW-2:0];
      s4_cneg <= s3_c[CCW-1];
      // Stage 5: partial products of h*h and a*|c|.
      s5_ray  <= s4_ray;
      s5_a    <= s4_a;
      s5_h    <= s4_h;
      s5_cneg <= s4_cneg;
      s5_phh  <= s4_hm[64:33] * s4_hm[64:33];
      s5_phx  <= s4_hm[64:33] * s4_hm[32:0];
      s5_pll  <= s4_hm[32:0] * s4_hm[32:0];
      s5_pa0  <= s4_a[31:0] * s4_cm[33:0];
      s5_pa1  <= s4_a[31:0] * s4_cm[66:34];
      s5_pa2  <= s4_a[63:32] * s4_cm[33:0];
      s5_pa3  <= s4_a[63:32] * s4_cm[66:34];
      // Stage 6: recombine.
      s6_ray  <= s5_ray;
      s6_a    <= s5_a;
      s6_h    <= s5_h;
      s6_cneg <= s5_cneg;
      s6_h2   <= {s5_phh, 66'd0} + {s5_phx, 34'd0} + s5_pll;
      s6_ac   <= {s5_pa3, 66'd0} + {s5_pa2, 32'd0} + {s5_pa1, 34'd0} + s5_pa0;
      // Stage 7: discriminant.
      s7_ray  <= s6_ray;
      s7_a    <= s6_a;
      s7_h    <= s6_h;
      s7_disc <= s6_cneg ? s6_h2 + s6_ac : s6_h2 - s6_ac;
    end
  end

  always_comb begin
    out.vld       = s7_vld;
    out.disc      = s7_disc;
    out.side.ray  = s7_ray;
    out.side.h    = s7_h;
    out.side.a    = s7_a;
    out.side.miss = 1'b0;
  end

endmodule

// File: rtl/rsi_sqrt.sv
// Pipelined floor square root of the discriminant, one result bit per stage.
// Also flags the miss cases (discriminant not positive, zero direction). Uses rsi_pkg.
module rsi_sqrt import rsi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  sq_in_t  in,
  output sq_out_t out
);

  typedef struct packed {
    logic          vld;
    logic [SW+1:0] rem;
    logic [SW-1:0] root;
    logic [QW-1:0] rad;
    sq_side_t      side;
  } sq_stage_t;

  sq_stage_t head;
  sq_stage_t stg [SW];

  function automatic sq_stage_t sq_step(input sq_stage_t s);
    sq_stage_t     r;
    logic [SW+1:0] r2;
    logic [SW+1:0] trial;
    logic          ge;
    r     = s;
    r2    = {s.rem[SW-1:0], s.rad[QW-1 -: 2]};
    trial = {s.root, 2'b01};
    ge    = r2 >= trial;
    r.rem  = ge ? r2 - trial : r2;
    r.root = {s.root[SW-2:0], ge};
    r.rad  = {s.rad[QW-3:0], 2'b00};
    return r;
  endfunction

  always_comb begin
    logic miss;
    miss = in.disc[QW-1] || (in.disc == '0) || (in.side.a == '0);
    head.vld       = in.vld;
    head.rem       = '0;
    head.root      = '0;
    head.rad       = miss ? '0 : in.disc;
    head.side      = in.side;
    head.side.miss = miss;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SW; k++) begin
        stg[k].vld <= 1'b0;
      end
    end else if (en) begin
      stg[0] <= sq_step(head);
      for (int k = 1; k < SW; k++) begin
        stg[k] <= sq_step(stg[k-1]);
      end
    end
  end

  always_comb begin
    out.vld  = stg[SW-1].vld;
    out.root = stg[SW-1].root;
    out.side = stg[SW-1].side;
  end

endmodule

// File: rtl/rsi_div.sv
// Pipelined restoring divider: unsigned quotient of QB bits, one bit per stage.
// The dividend must stay below the divisor times 2^QB unless ovf is set. Uses rsi_pkg.
module rsi_div import rsi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  div_in_t  in,
  output div_out_t out
);

  typedef struct packed {
    logic              vld;
    logic [DNW-1:0]    rem;
    logic [QB-1:0]     low;
    logic [DNW-1:0]    den;
    logic              neg;
    logic              ovf;
    logic [SIDE_W-1:0] side;
  } div_stage_t;

  div_stage_t head;
  div_stage_t stg [QB];

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t   r;
    logic [DNW:0] r2;
    logic [DNW:0] diff;
    logic         ge;
    r    = s;
    r2   = {s.rem, s.low[QB-1]};
    diff = r2 - {1'b0, s.den};
    ge   = r2 >= {1'b0, s.den};
    r.rem = ge ? diff[DNW-1:0] : r2[DNW-1:0];
    r.low = {s.low[QB-2:0], ge};
    return r;
  endfunction

  always_comb begin
    head.vld  = in.vld;
    head.rem  = in.num[NW-1:QB];
    head.low  = in.num[QB-1:0];
    head.den  = in.den;
    head.neg  = in.neg;
    head.ovf  = in.ovf;
    head.side = in.side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QB; k++) begin
        stg[k].vld <= 1'b0;
      end
    end else if (en) begin
      stg[0] <= div_step(head);
      for (int k = 1; k < QB; k++) begin
        stg[k] <= div_step(stg[k-1]);
      end
    end
  end

  always_comb begin
    out.vld  = stg[QB-1].vld;
    out.quo  = stg[QB-1].low;
    out.rnz  = |stg[QB-1].rem;
    out.neg  = stg[QB-1].neg;
    out.ovf  = stg[QB-1].ovf;
    out.side = stg[QB-1].side;
  end

endmodule

// File: rtl/ray_sphere_intersect.sv
// Top level of the ray-sphere tester; holds the sphere registers and root/point/normal stages.
// Depends on rsi_pkg, rsi_if, rsi_quad, rsi_sqrt and rsi_div.

// The block accepts one ray per clock cycle while the pipeline advances, and returns one
// result transaction per ray, in order. The pipeline is made of seven stages of quadratic
// setup, a 66-stage square root (one result bit per stage), two stages to form and scale
// the roots, two 32-stage dividers running side by side for the near and far root, four
// stages for root selection and the hit point, three 32-stage dividers for the normal, and
// the output register. The whole pipeline advances together: it moves whenever the output
// register is empty or its transaction is being taken, and holds every stage while a
// result waits, so nothing is dropped or repeated. The sphere registers (center, radius,
// material) are written over the cfg channel, which is always ready; write them only while
// no ray is in flight. Indexes past the material register are ignored. A miss returns all
// fields zero; a zero radius returns zero normals.
module ray_sphere_intersect import rsi_pkg::*; (
  input logic      clk,
  input logic      rst,
  rsi_ray_if.sink  ray,
  rsi_hit_if.source result,
  rsi_cfg_if.sink  cfg
);

  // Sphere registers.
  coord_t [2:0]  center;
  logic [RW-1:0] radius;
  logic [MW-1:0] material;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center   <= '0;
      radius   <= RW'(1 << FB);
      material <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_CENTER_X: center[0] <= cfg.data;
        REG_CENTER_Y: center[1] <= cfg.data;
        REG_CENTER_Z: center[2] <= cfg.data;
        REG_RADIUS:   radius    <= cfg.data[RW-1:0];
        REG_MATERIAL: material  <= cfg.data[MW-1:0];
        default: ;
      endcase
    end
  end

  // One enable for the whole pipeline: advance unless a result is held at the output.
  logic o_vld;
  logic en;

  assign en        = !o_vld || result.ready;
  assign ray.ready = en;

  ray_t in_ray;

  always_comb begin
    in_ray.org[0] = ray.origin_x;
    in_ray.org[1] = ray.origin_y;
    in_ray.org[2] = ray.origin_z;
    in_ray.dir[0] = ray.dir_x;
    in_ray.dir[1] = ray.dir_y;
    in_ray.dir[2] = ray.dir_z;
    in_ray.t_min  = ray.t_min;
    in_ray.t_max  = ray.t_max;
  end

  sq_in_t  sq_in;
  sq_out_t sq_out;

  rsi_quad u_quad (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (ray.valid),
    .in_ray (in_ray),
    .center (center),
    .radius (radius),
    .out    (sq_in)
  );

  rsi_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .in  (sq_in),
    .out (sq_out)
  );

  // Root numerators -h - s and -h + s.
  logic                   r1_vld;
  logic signed [NUMW-1:0] r1_nn, r1_nf;
  sq_side_t               r1_side;
  logic signed [NUMW-1:0] h_ext, s_ext;

  assign h_ext = $signed({{(NUMW-HW){sq_out.side.h[HW-1]}}, sq_out.side.h});
  assign s_ext = $signed({{(NUMW-SW){1'b0}}, sq_out.root});

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_vld <= 1'b0;
    end else if (en) begin
      r1_vld <= sq_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_nn   <= -h_ext - s_ext;
      r1_nf   <= -h_ext + s_ext;
      r1_side <= sq_out.side;
    end
  end

  // Scale the numerators by 2^FB and check whether the quotient fits QB bits.
  div_in_t dn_in, df_in, dn_next, df_next;
  div_out_t dn_out, df_out;

  always_comb begin
    logic signed [NUMW-1:0] mag_n;
    logic signed [NUMW-1:0] mag_f;
    tside_t                 ts;
    mag_n   = r1_nn[NUMW-1] ? -r1_nn : r1_nn;
    mag_f   = r1_nf[NUMW-1] ? -r1_nf : r1_nf;
    ts.miss = r1_side.miss;
    ts.ray  = r1_side.ray;
    dn_next.vld  = r1_vld;
    dn_next.num  = {{(NW-NUMW+1-FB){1'b0}}, mag_n[NUMW-2:0], {FB{1'b0}}};
    dn_next.den  = r1_side.a;
    dn_next.neg  = r1_nn[NUMW-1];
    dn_next.ovf  = mag_n[NUMW-2:0] >= {r1_side.a, {FB{1'b0}}};
    dn_next.side = ts;
    df_next.vld  = r1_vld;
    df_next.num  = {{(NW-NUMW+1-FB){1'b0}}, mag_f[NUMW-2:0], {FB{1'b0}}};
    df_next.den  = r1_side.a;
    df_next.neg  = r1_nf[NUMW-1];
    df_next.ovf  = mag_f[NUMW-2:0] >= {r1_side.a, {FB{1'b0}}};
    df_next.side = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_in.vld <= 1'b0;
      df_in.vld <= 1'b0;
    end else if (en) begin
      dn_in <= dn_next;
      df_in <= df_next;
    end
  end

  rsi_div u_div_near (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .in  (dn_in),
    .out (dn_out)
  );

  rsi_div u_div_far (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .in  (df_in),
    .out (df_out)
  );

  // Floor the signed quotients and pick the near root if it is inside the window.
  logic         r3_vld, r3_hit;
  coord_t       r3_t;
  ray_t         r3_ray;
  tside_t       r3_ts;
  logic signed [TW-1:0] tn, tf, tlo, thi;
  logic         in_n, in_f;

  always_comb begin
    r3_ts = tside_t'(dn_out.side);
    tn = dn_out.neg ? -$signed({2'b00, dn_out.quo}) - $signed({{(TW-1){1'b0}}, dn_out.rnz})
                    : $signed({2'b00, dn_out.quo});
    tf = df_out.neg ? -$signed({2'b00, df_out.quo}) - $signed({{(TW-1){1'b0}}, df_out.rnz})
                    : $signed({2'b00, df_out.quo});
    tlo  = $signed({{(TW-CW){r3_ts.ray.t_min[CW-1]}}, r3_ts.ray.t_min});
    thi  = $signed({{(TW-CW){r3_ts.ray.t_max[CW-1]}}, r3_ts.ray.t_max});
    in_n = !dn_out.ovf && (tn > tlo) && (tn < thi);
    in_f = !df_out.ovf && (tf > tlo) && (tf < thi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_vld <= 1'b0;
    end else if (en) begin
      r3_vld <= dn_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_hit <= !r3_ts.miss && (in_n || in_f);
      r3_t   <= in_n ? tn[CW-1:0] : tf[CW-1:0];
      r3_ray <= r3_ts.ray;
    end
  end

  // Hit point: O + floor(t * D / 2^FB), saturated.
  logic                    p1_vld, p1_hit, p2_vld, p2_hit;
  coord_t                  p1_t, p2_t;
  coord_t [2:0]            p1_org, p2_pnt;
  logic signed [SATW-1:0]  p1_prod [3];
  logic signed [SATW-1:0]  psum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = $signed({{(SATW-CW){p1_org[i][CW-1]}}, p1_org[i]}) + (p1_prod[i] >>> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= r3_vld;
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_hit <= r3_hit;
      p1_t   <= r3_t;
      p1_org <= r3_ray.org;
      for (int i = 0; i < 3; i++) begin
        p1_prod[i] <= r3_t * $signed(r3_ray.dir[i]);
      end
      p2_hit <= p1_hit;
      p2_t   <= p1_t;
      for (int i = 0; i < 3; i++) begin
        p2_pnt[i] <= sat_coord(psum[i]);
      end
    end
  end

  // Normal division setup: |point - center| * 2^FB over the radius.
  div_in_t  nd_in [3];
  div_in_t  nd_next [3];
  div_out_t nd_out [3];

  always_comb begin
    logic signed [VW-1:0] diff;
    logic signed [VW-1:0] mag;
    nside_t               ns;
    ns.hit = p2_hit;
    ns.t   = p2_t;
    ns.pnt = p2_pnt;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({p2_pnt[i][CW-1], p2_pnt[i]}) - $signed({center[i][CW-1], center[i]});
      mag  = diff[VW-1] ? -diff : diff;
      nd_next[i].vld  = p2_vld;
      nd_next[i].num  = {{(NW-VW-FB){1'b0}}, mag, {FB{1'b0}}};
      nd_next[i].den  = {{(DNW-RW){1'b0}}, radius};
      nd_next[i].neg  = diff[VW-1];
      nd_next[i].ovf  = mag >= {radius, {FB{1'b0}}};
      nd_next[i].side = '0;
    end
    nd_next[0].side = {{(SIDE_W-$bits(nside_t)){1'b0}}, ns};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        nd_in[i].vld <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < 3; i++) begin
        nd_in[i] <= nd_next[i];
      end
    end
  end

  rsi_div u_div_nx (.clk(clk), .rst(rst), .en(en), .in(nd_in[0]), .out(nd_out[0]));
  rsi_div u_div_ny (.clk(clk), .rst(rst), .en(en), .in(nd_in[1]), .out(nd_out[1]));
  rsi_div u_div_nz (.clk(clk), .rst(rst), .en(en), .in(nd_in[2]), .out(nd_out[2]));

  // Final floor and saturation of the normal, then the output register.
  nside_t       f_ns;
  coord_t [2:0] nrm;
  logic         o_hit;
  coord_t       o_t;
  coord_t [2:0] o_pnt, o_nrm;
  logic [MW-1:0] o_mat;

  always_comb begin
    logic signed [TW-1:0] q;
    f_ns = nside_t'(nd_out[0].side[$bits(nside_t)-1:0]);
    for (int i = 0; i < 3; i++) begin
      q = nd_out[i].neg
          ? -$signed({2'b00, nd_out[i].quo}) - $signed({{(TW-1){1'b0}}, nd_out[i].rnz})
          : $signed({2'b00, nd_out[i].quo});
      if (radius == '0) begin
        nrm[i] = '0;
      end else if (nd_out[i].ovf) begin
        nrm[i] = nd_out[i].neg ? COORD_MIN : COORD_MAX;
      end else begin
        nrm[i] = sat_coord($signed({{(SATW-TW){q[TW-1]}}, q}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= nd_out[0].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit <= f_ns.hit;
      o_t   <= f_ns.hit ? f_ns.t : '0;
      o_pnt <= f_ns.hit ? f_ns.pnt : '0;
      o_nrm <= f_ns.hit ? nrm : '0;
      o_mat <= f_ns.hit ? material : '0;
    end
  end

  assign result.valid        = o_vld;
  assign result.hit          = o_hit;
  assign result.hit_t        = o_t;
  assign result.point_x      = o_pnt[0];
  assign result.point_y      = o_pnt[1];
  assign result.point_z      = o_pnt[2];
  assign result.normal_x     = o_nrm[0];
  assign result.normal_y     = o_nrm[1];
  assign result.normal_z     = o_nrm[2];
  assign result.hit_material = o_mat;

endmodule
